/* sv/ces_pkg.sv */
// ----------------------------------------------------------------------------
// ces_pkg
// Shared constants and types for the chunked ELLPACK SpMV core.
// ----------------------------------------------------------------------------
package ces_pkg;

  // fixed field widths
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int ROW_OUT_W = 10;

  // sizing
  localparam int CHUNK_HEIGHT = 8;
  localparam int VECTOR_DEPTH = 1024;
  localparam int ROW_DEPTH    = 1024;

  localparam int LANE_W  = (CHUNK_HEIGHT > 1) ? $clog2(CHUNK_HEIGHT) : 1;
  localparam int VEC_AW  = $clog2(VECTOR_DEPTH);
  localparam int ROW_AW  = $clog2(ROW_DEPTH);
  localparam int ROW_W   = ROW_AW + 1;
  localparam int CHUNK_W = ROW_AW;

  localparam int SUM_W  = 64;
  localparam int FRAC_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_VEC  = 3'd0,
    CMD_LOAD_OLD  = 3'd1,
    CMD_MAC       = 3'd2,
    CMD_END_CHUNK = 3'd3,
    CMD_START     = 3'd4
  } cmd_t;

endpackage

/* sv/ces_in_if.sv */
// ----------------------------------------------------------------------------
// ces_in_if
// Input channel: command beats with index and Q16.16 value.
// ----------------------------------------------------------------------------
interface ces_in_if import ces_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

/* sv/ces_out_if.sv */
// ----------------------------------------------------------------------------
// ces_out_if
// Result channel: one row result per beat.
// ----------------------------------------------------------------------------
interface ces_out_if import ces_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_OUT_W-1:0]    row_index;
  logic signed [VAL_W-1:0] result_value;
  logic                    last;

  modport source (output valid, row_index, result_value, last, input ready);
  modport sink   (input valid, row_index, result_value, last, output ready);
endinterface

/* sv/ces_cfg_if.sv */
// ----------------------------------------------------------------------------
// ces_cfg_if
// Configuration write channel for the accumulate mode bit.
// ----------------------------------------------------------------------------
interface ces_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/ces_ram.sv */
// ----------------------------------------------------------------------------
// ces_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ces_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while rd_en is low
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/chunked_ellpack_spmv_core.sv */
// ----------------------------------------------------------------------------
// chunked_ellpack_spmv_core
// Sparse matrix times dense vector, chunked ELLPACK order, Q16.16 values.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_bus    in   valid/ready      command, index, value
//  out_bus   out  valid/ready      row_index, result_value, last
//  cfg_bus   in   valid/ready      data (accumulate mode)
//
//  loads, matrix elements and start beats are taken one per cycle when ready
//  an end-chunk beat drops in_ready until its CHUNK_HEIGHT rows are issued:
//  it first passes stages s1 and s2 of the multiply pipe, then rows issue one
//  per cycle unless the output stalls, each with one old-result memory read
//  rst_n is synchronous: lanes, counters, mode and valid flags clear
//  output stalls hold the row sequencer; out register parts the two sides
//
module chunked_ellpack_spmv_core import ces_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ces_in_if.sink     in_bus,
  ces_out_if.source  out_bus,
  ces_cfg_if.sink    cfg_bus
);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic accumulate_mode_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accumulate_mode_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      accumulate_mode_r <= cfg_bus.data;
    end
  end

  // --------------------------------------------------------------------------
  // input accept and memory writes
  // --------------------------------------------------------------------------
  logic busy_r;      // end chunk in flight, no new beats
  logic in_accept;
  cmd_t in_cmd;
  logic vec_in_range;
  logic row_in_range;

  assign in_bus.ready = !busy_r;
  assign in_accept    = in_bus.valid && in_bus.ready;
  assign in_cmd       = cmd_t'(in_bus.command);
  assign vec_in_range = 32'(in_bus.index) < 32'(VECTOR_DEPTH);
  assign row_in_range = 32'(in_bus.index) < 32'(ROW_DEPTH);

  logic             vec_wr_en;
  logic             vec_rd_en;
  logic [VAL_W-1:0] vec_rd_data;

  assign vec_wr_en = in_accept && (in_cmd == CMD_LOAD_VEC) && vec_in_range;
  assign vec_rd_en = in_accept && (in_cmd == CMD_MAC);

  ces_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (vec_wr_en),
    .wr_addr (VEC_AW'(in_bus.index)),
    .wr_data (in_bus.value),
    .rd_en   (vec_rd_en),
    .rd_addr (VEC_AW'(in_bus.index)),
    .rd_data (vec_rd_data)
  );

  logic              old_wr_en;
  logic              old_rd_en;
  logic [ROW_AW-1:0] old_rd_addr;
  logic [VAL_W-1:0]  old_rd_data;

  assign old_wr_en = in_accept && (in_cmd == CMD_LOAD_OLD) && row_in_range;

  ces_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ROW_DEPTH)
  ) u_old_ram (
    .clk     (clk),
    .wr_en   (old_wr_en),
    .wr_addr (ROW_AW'(in_bus.index)),
    .wr_data (in_bus.value),
    .rd_en   (old_rd_en),
    .rd_addr (old_rd_addr),
    .rd_data (old_rd_data)
  );

  // --------------------------------------------------------------------------
  // stage 1: dense entry comes back from memory, multiply
  // --------------------------------------------------------------------------
  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;
  logic signed [VAL_W-1:0] s1_value_r;
  logic                    s1_oob_r;   // column beyond the dense store reads zero

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      // only beats that touch the lanes travel down the pipe
      s1_valid_r <= in_accept && ((in_cmd == CMD_MAC) || (in_cmd == CMD_END_CHUNK) ||
                                  (in_cmd == CMD_START));
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r   <= in_cmd;
    s1_value_r <= in_bus.value;
    s1_oob_r   <= !vec_in_range;
  end

  logic signed [VAL_W-1:0] dense_x;
  logic signed [SUM_W-1:0] prod_nxt;

  assign dense_x  = s1_oob_r ? '0 : $signed(vec_rd_data);
  assign prod_nxt = SUM_W'(s1_value_r) * SUM_W'(dense_x);

  // --------------------------------------------------------------------------
  // stage 2: lane accumulate, start clears, end chunk launches the row sequencer
  // --------------------------------------------------------------------------
  logic                    s2_valid_r;
  cmd_t                    s2_cmd_r;
  logic signed [SUM_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd_r  <= s1_cmd_r;
    s2_prod_r <= prod_nxt;
  end

  logic signed [SUM_W-1:0] lane_sums_r [CHUNK_HEIGHT];
  logic [LANE_W-1:0]       lane_cnt_r;
  logic [CHUNK_W-1:0]      chunk_cnt_r;

  // row sequencer
  logic              emit_active_r;
  logic [LANE_W-1:0] emit_cnt_r;
  logic              emit_issue;
  logic              emit_done;

  // e1: row issued, old result read in flight
  logic                    e1_valid_r;
  logic [ROW_OUT_W-1:0]    e1_row_r;
  logic signed [SUM_W-1:0] e1_sum_r;
  logic                    e1_use_old_r;
  logic                    e1_last_r;
  logic                    e1_adv;
  logic                    out_free;

  // output register
  logic                    out_valid_r;
  logic [ROW_OUT_W-1:0]    out_row_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;

  assign out_free   = !out_valid_r || out_bus.ready;
  assign e1_adv     = e1_valid_r && out_free;
  assign emit_issue = emit_active_r && (!e1_valid_r || e1_adv);
  assign emit_done  = emit_issue && (emit_cnt_r == LANE_W'(CHUNK_HEIGHT - 1));

  logic signed [SUM_W-1:0] mac_term;
  logic                    mac_en;
  logic                    lanes_clear;

  assign mac_term    = s2_prod_r >>> FRAC_W;   // floor of the Q32.32 product
  assign mac_en      = s2_valid_r && (s2_cmd_r == CMD_MAC);
  assign lanes_clear = (s2_valid_r && (s2_cmd_r == CMD_START)) || emit_done;

  // row and chunk bookkeeping
  logic [31:0]       chunk_base;
  logic [ROW_W-1:0]  emit_row;
  logic [31:0]       emit_row_ext;
  logic              chunk_wrap;

  assign chunk_base   = 32'(chunk_cnt_r) * 32'(CHUNK_HEIGHT);
  assign emit_row     = ROW_W'(chunk_base + 32'(emit_cnt_r));
  assign emit_row_ext = 32'(emit_row);
  assign chunk_wrap   = (chunk_base + 32'(2 * CHUNK_HEIGHT)) > 32'(ROW_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHUNK_HEIGHT; i++) begin
        lane_sums_r[i] <= '0;
      end
      lane_cnt_r <= '0;
    end else if (lanes_clear) begin
      for (int i = 0; i < CHUNK_HEIGHT; i++) begin
        lane_sums_r[i] <= '0;
      end
      lane_cnt_r <= '0;
    end else if (mac_en) begin
      lane_sums_r[lane_cnt_r] <= lane_sums_r[lane_cnt_r] + mac_term;
      if (lane_cnt_r == LANE_W'(CHUNK_HEIGHT - 1)) begin
        lane_cnt_r <= '0;
      end else begin
        lane_cnt_r <= lane_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_cnt_r <= '0;
    end else if (s2_valid_r && (s2_cmd_r == CMD_START)) begin
      chunk_cnt_r <= '0;
    end else if (emit_done) begin
      chunk_cnt_r <= chunk_wrap ? '0 : chunk_cnt_r + 1'b1;
    end
  end

  // busy from end-chunk accept until the last row has been issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_accept && (in_cmd == CMD_END_CHUNK)) begin
      busy_r <= 1'b1;
    end else if (emit_done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_active_r <= 1'b0;
      emit_cnt_r    <= '0;
    end else if (s2_valid_r && (s2_cmd_r == CMD_END_CHUNK)) begin
      emit_active_r <= 1'b1;
      emit_cnt_r    <= '0;
    end else if (emit_done) begin
      emit_active_r <= 1'b0;
    end else if (emit_issue) begin
      emit_cnt_r <= emit_cnt_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // row issue: clamp lane sum to +-2^62, read old result
  // --------------------------------------------------------------------------
  localparam logic signed [SUM_W-1:0] LANE_CLAMP = SUM_W'(64'sd1 <<< 62);

  logic signed [SUM_W-1:0] lane_pick;
  logic signed [SUM_W-1:0] lane_clamped;
  logic                    row_valid;

  assign lane_pick = lane_sums_r[emit_cnt_r];
  always_comb begin
    if (lane_pick > LANE_CLAMP) begin
      lane_clamped = LANE_CLAMP;
    end else if (lane_pick < -LANE_CLAMP) begin
      lane_clamped = -LANE_CLAMP;
    end else begin
      lane_clamped = lane_pick;
    end
  end

  assign row_valid   = emit_row_ext < 32'(ROW_DEPTH);
  assign old_rd_en   = emit_issue;
  assign old_rd_addr = ROW_AW'(emit_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
    end else if (emit_issue) begin
      e1_valid_r <= 1'b1;
    end else if (e1_adv) begin
      e1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_issue) begin
      e1_row_r     <= emit_row_ext[ROW_OUT_W-1:0];
      e1_sum_r     <= lane_clamped;
      e1_use_old_r <= accumulate_mode_r && row_valid;
      e1_last_r    <= (emit_cnt_r == LANE_W'(CHUNK_HEIGHT - 1));
    end
  end

  // --------------------------------------------------------------------------
  // add old result, saturate to 32 bits, output register
  // --------------------------------------------------------------------------
  localparam logic signed [SUM_W-1:0] I32_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] I32_MIN = -SUM_W'(64'sd2147483648);

  logic signed [SUM_W-1:0] old_term;
  logic signed [SUM_W-1:0] row_sum;
  logic signed [VAL_W-1:0] row_sat;

  assign old_term = e1_use_old_r ? SUM_W'($signed(old_rd_data)) : '0;
  assign row_sum  = e1_sum_r + old_term;

  always_comb begin
    if (row_sum > I32_MAX) begin
      row_sat = VAL_W'(I32_MAX);
    end else if (row_sum < I32_MIN) begin
      row_sat = VAL_W'(I32_MIN);
    end else begin
      row_sat = row_sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_adv) begin
      out_row_r   <= e1_row_r;
      out_value_r <= row_sat;
      out_last_r  <= e1_last_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.row_index    = out_row_r;
  assign out_bus.result_value = out_value_r;
  assign out_bus.last         = out_last_r;

endmodule

/* dv/spmv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmv_checker
// Watches the three channels of the SpMV core, keeps its own copy of the
// vector stores, lane sums and chunk position, and compares each row result
// beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module spmv_checker import ces_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ces_in_if    in_bus,
  ces_out_if   out_bus,
  ces_cfg_if   cfg_bus,
  output int   mismatches,
  output int   rows_due
);

  typedef struct packed {
    logic [ROW_OUT_W-1:0]    row;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } row_beat_t;

  localparam longint SUM_CLAMP = longint'(1) <<< 62;
  localparam longint Q_MAX     = 64'sd2147483647;
  localparam longint Q_MIN     = -64'sd2147483648;

  logic signed [VAL_W-1:0] x_mem     [VECTOR_DEPTH];
  logic signed [VAL_W-1:0] y_old_mem [ROW_DEPTH];
  logic [SUM_W-1:0]        lane_sum  [CHUNK_HEIGHT];
  int unsigned             next_lane;
  int unsigned             chunk_no;
  logic                    add_old;
  row_beat_t               rows_expected [$];
  int                      err_count    = 0;
  int                      rows_waiting = 0;

  assign mismatches = err_count;
  assign rows_due   = rows_waiting;

  task automatic clear_lanes();
    foreach (lane_sum[i]) lane_sum[i] = '0;
    next_lane = 0;
  endtask

  task automatic predict_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val);
    longint      prod;
    longint      s;
    int unsigned row_base;
    int unsigned row;
    row_beat_t   rb;
    case (cmd)
      CMD_LOAD_VEC: begin
        if (idx < VECTOR_DEPTH) x_mem[idx] = val;
      end
      CMD_LOAD_OLD: begin
        if (idx < ROW_DEPTH) y_old_mem[idx] = val;
      end
      CMD_MAC: begin
        prod = 0;
        if (idx < VECTOR_DEPTH) prod = longint'(val) * longint'(x_mem[idx]);
        // floor of the q16.16 product, lane sums wrap at 64 bits
        prod = prod >>> FRAC_W;
        lane_sum[next_lane] = lane_sum[next_lane] + prod;
        next_lane = (next_lane + 1) % CHUNK_HEIGHT;
      end
      CMD_END_CHUNK: begin
        row_base = chunk_no * CHUNK_HEIGHT;
        for (int i = 0; i < CHUNK_HEIGHT; i++) begin
          row = row_base + i;
          s = lane_sum[i];
          if (s > SUM_CLAMP) s = SUM_CLAMP;
          if (s < -SUM_CLAMP) s = -SUM_CLAMP;
          if (add_old && row < ROW_DEPTH) s = s + y_old_mem[row];
          if (s > Q_MAX) s = Q_MAX;
          if (s < Q_MIN) s = Q_MIN;
          rb.row   = row[ROW_OUT_W-1:0];
          rb.value = s[VAL_W-1:0];
          rb.last  = (i == CHUNK_HEIGHT - 1);
          rows_expected.push_back(rb);
        end
        clear_lanes();
        if (row_base + 2 * CHUNK_HEIGHT > ROW_DEPTH) chunk_no = 0;
        else chunk_no = chunk_no + 1;
      end
      CMD_START: begin
        clear_lanes();
        chunk_no = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    row_beat_t want;
    row_beat_t got;
    if (!rst_n) begin
      foreach (x_mem[i]) x_mem[i] = '0;
      foreach (y_old_mem[i]) y_old_mem[i] = '0;
      clear_lanes();
      chunk_no = 0;
      add_old  = 1'b0;
      rows_expected.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.row   = out_bus.row_index;
        got.value = out_bus.result_value;
        got.last  = out_bus.last;
        if (rows_expected.size() == 0) begin
          $display("%0t: row beat with none expected: got row %0d value %0d last %0b",
                   $time, got.row, got.value, got.last);
          err_count <= err_count + 1;
        end else begin
          want = rows_expected.pop_front();
          if (got !== want) begin
            $display({"%0t: row mismatch: expected row %0d value %0d last %0b, ",
                      "got row %0d value %0d last %0b"},
                     $time, want.row, want.value, want.last, got.row, got.value, got.last);
            err_count <= err_count + 1;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) add_old = cfg_bus.data;
      if (in_bus.valid && in_bus.ready)
        predict_beat(in_bus.command, in_bus.index, in_bus.value);
    end
    rows_waiting <= rows_expected.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the chunked ELLPACK SpMV core: directed corner
// beats, then random well-formed chunks with noise under several idle and
// stall patterns, in both accumulate settings, and a long chunk sweep.
// ----------------------------------------------------------------------------
module tb_top import ces_pkg::*;;

  // quiet cycles before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // an end-chunk beat keeps the core busy until its last row is issued
  localparam int SETTLE_CYCLES  = 2 * CHUNK_HEIGHT + 8;
  localparam int PHASE_BEATS    = 25;
  // enough end-chunk beats to walk the chunk counter past its wrap point
  localparam int SWEEP_CHUNKS   = ROW_DEPTH / CHUNK_HEIGHT + 2;
  // commands the core must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  ces_in_if  in_bus();
  ces_out_if out_bus();
  ces_cfg_if cfg_bus();

  int   mismatches;
  int   rows_due;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic rx_ready  = 1'b0;
  int   quiet_cycles = 0;

  // what the stimulus has written so far, so that no unwritten entry is read
  bit               vec_loaded [VECTOR_DEPTH];
  bit               old_loaded [ROW_DEPTH];
  logic [IDX_W-1:0] vec_cols [$];
  int unsigned      gen_chunk   = 0;
  bit               gen_add_old = 1'b0;
  int               beats_sent  = 0;

  chunked_ellpack_spmv_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  spmv_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_bus    (cfg_bus),
    .mismatches (mismatches),
    .rows_due   (rows_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls at the current rate
  assign out_bus.ready = rx_ready;
  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hang detection: any accepted beat on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // idle/stall patterns: none, sender only, receiver only, both lightly
  task automatic set_pressure(input int p);
    case (p)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 51; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 51; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // mostly small q16.16 values so sums stay in range, with the extremes mixed in
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom();
      default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // one input beat; valid stays high into the next beat unless a gap is rolled
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.index   <= idx;
    in_bus.value   <= val;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    // track stores and chunk position the way the core will see them
    case (cmd)
      CMD_LOAD_VEC: begin
        if (!vec_loaded[idx]) begin
          vec_loaded[idx] = 1'b1;
          vec_cols.push_back(idx);
        end
      end
      CMD_LOAD_OLD: old_loaded[idx] = 1'b1;
      CMD_END_CHUNK: begin
        if ((gen_chunk + 2) * CHUNK_HEIGHT > ROW_DEPTH) gen_chunk = 0;
        else gen_chunk = gen_chunk + 1;
      end
      CMD_START: gen_chunk = 0;
      default: ;
    endcase
    if (cmd <= CMD_START) beats_sent++;
  endtask

  // matrix element against an already loaded column
  task automatic mac_beat();
    send_beat(CMD_MAC, vec_cols[$urandom_range(vec_cols.size() - 1)], pick_value());
  endtask

  // end the chunk; in accumulate mode make sure its old-result rows exist first
  task automatic close_chunk();
    int unsigned row;
    if (gen_add_old) begin
      for (int r = 0; r < CHUNK_HEIGHT; r++) begin
        row = gen_chunk * CHUNK_HEIGHT + r;
        if (!old_loaded[row]) send_beat(CMD_LOAD_OLD, row[IDX_W-1:0], pick_value());
      end
    end
    send_beat(CMD_END_CHUNK, IDX_W'($urandom_range(1023)), $urandom());
  endtask

  // loads anywhere, ignored commands, and the odd restart that breaks a chunk
  task automatic noise_beat();
    case ($urandom_range(7))
      0, 1, 2: send_beat(CMD_LOAD_VEC, IDX_W'($urandom_range(1023)), pick_value());
      3, 4: send_beat(CMD_LOAD_OLD, IDX_W'($urandom_range(1023)), pick_value());
      5, 6: send_beat(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                      IDX_W'($urandom_range(1023)), $urandom());
      default: send_beat(CMD_START, IDX_W'($urandom_range(1023)), $urandom());
    endcase
  endtask

  // a chunk of whole columns half of the time, otherwise short or ragged
  task automatic random_chunk();
    int n;
    case ($urandom_range(3))
      0: n = $urandom_range(3);
      1, 2: n = CHUNK_HEIGHT * $urandom_range(1, 2);
      default: n = $urandom_range(1, 3 * CHUNK_HEIGHT);
    endcase
    repeat (n) begin
      if ($urandom_range(15) == 0) noise_beat();
      mac_beat();
    end
    close_chunk();
  endtask

  // wait until every predicted row is out, then let the core settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (rows_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // accumulate mode is only changed with the core idle
  task automatic write_mode(input logic mode);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= mode;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    gen_add_old = mode;
  endtask

  initial begin
    int phase_start;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.command <= '0;
    in_bus.index   <= '0;
    in_bus.value   <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.data   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // overwrite mode: extreme entries, saturation both ways, floor rounding
    write_mode(1'b0);
    send_beat(CMD_LOAD_VEC, '0, 32'h7fff_ffff);
    send_beat(CMD_LOAD_VEC, '1, 32'h8000_0000);
    send_beat(CMD_LOAD_VEC, 10'd5, 32'h0001_0000);
    send_beat(CMD_LOAD_VEC, 10'd6, 32'hffff_ffff);
    send_beat(CMD_START, '0, '0);
    send_beat(CMD_MAC, '0, 32'h7fff_ffff);     // lane 0 saturates high
    send_beat(CMD_MAC, '1, 32'h7fff_ffff);     // lane 1 saturates low
    send_beat(CMD_MAC, 10'd5, 32'h8000_0000);  // lane 2 lands exactly on the minimum
    send_beat(CMD_MAC, 10'd6, 32'h0000_0001);  // lane 3 rounds down to -1 lsb
    send_beat(CMD_MAC, 10'd6, 32'h8000_0000);  // lane 4, negative times negative
    close_chunk();                             // five elements, not a full column set
    send_beat(CMD_UNUSED_FIRST, IDX_W'($urandom_range(1023)), $urandom());
    send_beat(CMD_UNUSED_LAST, '1, 32'hffff_ffff);
    close_chunk();                             // empty chunk gives rows of zero value

    // accumulate mode: old results at both extremes
    write_mode(1'b1);
    send_beat(CMD_START, '1, 32'hffff_ffff);
    send_beat(CMD_LOAD_OLD, 10'd0, 32'h7fff_ffff);
    send_beat(CMD_LOAD_OLD, 10'd1, 32'h8000_0000);
    send_beat(CMD_MAC, '0, 32'h0001_0000);     // max plus max saturates
    close_chunk();

    // random chunks: each idle/stall pattern in both modes
    for (int p = 0; p < 8; p++) begin
      write_mode(p[0]);
      set_pressure(p / 2);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) random_chunk();
    end

    // long run of tiny chunks to take the chunk counter through its wrap
    write_mode(1'b0);
    set_pressure(3);
    send_beat(CMD_START, IDX_W'($urandom_range(1023)), $urandom());
    repeat (SWEEP_CHUNKS) begin
      if ($urandom_range(1) == 1) mac_beat();
      close_chunk();
    end

    drain();
    if (mismatches == 0 && rows_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ces_pkg.sv
sv/ces_in_if.sv
sv/ces_out_if.sv
sv/ces_cfg_if.sv
sv/ces_ram.sv
sv/chunked_ellpack_spmv_core.sv
dv/spmv_checker.sv
dv/tb_top.sv
